>>> design/tmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tmp_pkg;

    localparam int CMD_W   = 2;
    localparam int POS_W   = 32;
    localparam int VEL_W   = 33;
    localparam int LIM_W   = 32;
    localparam int TICK_W  = 16;
    localparam int IDX_W   = 2;
    localparam int OPA_W   = 64;
    localparam int OPB_W   = 32;

    localparam logic [CMD_W-1:0] CMD_PLAN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_MOVING = 2'd1;
    localparam logic [1:0] MODE_DONE   = 2'd2;

    localparam logic [IDX_W-1:0] REG_VEL_LIMIT   = 2'd0;
    localparam logic [IDX_W-1:0] REG_ACCEL_LIMIT = 2'd1;
    localparam logic [IDX_W-1:0] REG_TICK_PERIOD = 2'd2;

    localparam logic [LIM_W-1:0]  VEL_LIMIT_RST   = 32'd655360;
    localparam logic [LIM_W-1:0]  ACCEL_LIMIT_RST = 32'd3276800;
    localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 16'd66;

    typedef enum logic [1:0] {
        ALU_MUL  = 2'd0,
        ALU_DIV  = 2'd1,
        ALU_SQRT = 2'd2
    } t_alu_op;

    typedef enum logic [1:0] {
        SH_NONE = 2'd0,
        SH_F    = 2'd1,
        SH_F1   = 2'd2
    } t_shift;

    typedef struct packed {
        t_alu_op op;
        t_shift  sh;
        logic    cap;
    } t_alu_req;

endpackage
`default_nettype wire

>>> design/tmp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tmp_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [tmp_pkg::CMD_W-1:0]      command;
    logic signed [tmp_pkg::POS_W-1:0] start_position;
    logic signed [tmp_pkg::POS_W-1:0] target_position;
    modport source (output valid, command, start_position, target_position, input ready);
    modport sink   (input valid, command, start_position, target_position, output ready);
endinterface

interface tmp_res_if;
    logic                             valid;
    logic                             ready;
    logic                             accepted;
    logic [1:0]                       status;
    logic signed [tmp_pkg::POS_W-1:0] position;
    logic signed [tmp_pkg::VEL_W-1:0] velocity;
    logic signed [tmp_pkg::VEL_W-1:0] acceleration;
    modport source (output valid, accepted, status, position, velocity, acceleration,
                    input ready);
    modport sink   (input valid, accepted, status, position, velocity, acceleration,
                    output ready);
endinterface

interface tmp_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [tmp_pkg::IDX_W-1:0]  index;
    logic [tmp_pkg::LIM_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/trapezoidal_motion_profile.sv
`timescale 1ns / 1ps
`default_nettype none
// Trapezoidal velocity profile generator, signed fixed point, FRAC_BITS
// fraction bits.
// i_cmd: one item per command (plan, tick, stop). o_res: exactly one result
// item per command item: accepted, status, position, velocity, acceleration.
// i_cfg: register writes (velocity limit, accel limit, tick period), always
// ready; write only while no command is in flight.
// Work per command, from the accepted item to its result:
//   stop, unused code, rejected plan, zero-distance plan, idle tick,
//   end-of-move tick: no arithmetic, straight to the output register.
//   plan: a multiply and three divides with a cruise phase; a multiply,
//   two divides, a square root and a multiply for a triangular profile;
//   a multiply, two divides and a multiply when the ramp time saturates.
//   tick on the profile: 2, 3 or 6 multiplies for accel, cruise, decel.
// One command in flight at a time; all arithmetic goes through one shared
// multicycle unit, which sets the rate.
// The result sits in an output register; i_cmd.ready stays low while the
// block works or while that register holds an item the receiver stalls on.
// Reset: limits to their defaults, status idle, held position, velocity and acceleration zero.
module trapezoidal_motion_profile #(
    parameter int FRAC_BITS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tmp_cmd_if.sink    i_cmd,
    tmp_res_if.source  o_res,
    tmp_cfg_if.sink    i_cfg
);
    localparam int SHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SHR = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
    localparam logic signed [41:0] VMAX_P = 42'sd4294967295;
    localparam logic signed [41:0] VMAX_N = -42'sd4294967295;
    localparam logic signed [45:0] PMAX = 46'sd2147483647;
    localparam logic signed [45:0] PMIN = -46'sd2147483648;

    typedef enum logic [16:0] {
        ST_IDLE = 17'b00000000000000001,
        ST_FULL = 17'b00000000000000010,
        ST_FDIV = 17'b00000000000000100,
        ST_RAMP = 17'b00000000000001000,
        ST_CRU  = 17'b00000000000010000,
        ST_QDIV = 17'b00000000000100000,
        ST_SQRT = 17'b00000000001000000,
        ST_PEAK = 17'b00000000010000000,
        ST_FIN  = 17'b00000000100000000,
        ST_TA1  = 17'b00000001000000000,
        ST_TA2  = 17'b00000010000000000,
        ST_TPV  = 17'b00000100000000000,
        ST_TPD  = 17'b00001000000000000,
        ST_TB1  = 17'b00010000000000000,
        ST_TB2  = 17'b00100000000000000,
        ST_TEND = 17'b01000000000000000,
        ST_OUT  = 17'b10000000000000000
    } t_state;

    typedef enum logic [1:0] {
        PH_ACC = 2'd0,
        PH_CRU = 2'd1,
        PH_DEC = 2'd2
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    logic [31:0] r_vlim, r_alim;
    logic [15:0] r_tick;
    logic [1:0]  r_mode, n_mode;
    logic signed [31:0] r_origin, n_origin, r_goal, n_goal;
    logic        r_neg, n_neg;
    logic [31:0] r_dist, n_dist, r_ramp, n_ramp, r_cruise, n_cruise;
    logic [31:0] r_peak, n_peak, r_elapsed, n_elapsed, r_dur, n_dur;
    logic signed [31:0] r_hpos, n_hpos;
    logic signed [32:0] r_hvel, n_hvel, r_hacc, n_hacc;
    logic        r_accepted, n_accepted;
    logic [63:0] r_full, n_full;
    logic [40:0] r_m, n_m;
    logic signed [43:0] r_p, n_p;
    logic signed [41:0] r_v, n_v;
    logic [31:0] r_x1, n_x1, r_y3, n_y3;
    logic        r_issued, n_issued;
    logic        r_ovalid, n_ovalid;
    logic        r_oacc;
    logic [1:0]  r_ostat;
    logic signed [31:0] r_opos;
    logic signed [32:0] r_ovel, r_oacl;

    logic [31:0] v_eff, a_eff;
    logic        in_acc, alu_state, alu_start, alu_done;
    tmp_pkg::t_alu_req alu_req;
    logic [63:0] alu_opa, alu_res;
    logic [31:0] alu_opb;

    logic signed [32:0] diff;
    logic [31:0] abs_diff;
    logic [63:0] tick_eff;
    logic [32:0] el_sum, ta_tv;
    logic [31:0] el_next;
    logic signed [43:0] res_p;
    logic signed [41:0] pv;
    logic signed [43:0] pp;
    logic signed [45:0] pos_sum;
    logic        acc_flip;

    assign v_eff = (r_vlim == 32'd0) ? 32'd1 : r_vlim;
    assign a_eff = (r_alim == 32'd0) ? 32'd1 : r_alim;
    assign i_cmd.ready = (r_state == ST_IDLE) && (!r_ovalid || o_res.ready);
    assign in_acc = i_cmd.valid && i_cmd.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlim <= tmp_pkg::VEL_LIMIT_RST;
            r_alim <= tmp_pkg::ACCEL_LIMIT_RST;
            r_tick <= tmp_pkg::TICK_PERIOD_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tmp_pkg::REG_VEL_LIMIT:   r_vlim <= i_cfg.data;
                tmp_pkg::REG_ACCEL_LIMIT: r_alim <= i_cfg.data;
                tmp_pkg::REG_TICK_PERIOD: r_tick <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // request to the shared unit, by state
    always_comb begin
        alu_state = 1'b1;
        alu_req   = '{op: tmp_pkg::ALU_MUL, sh: tmp_pkg::SH_F, cap: 1'b1};
        alu_opa   = {32'd0, a_eff};
        alu_opb   = r_x1;
        case (r_state)
            ST_FULL: begin
                alu_req = '{op: tmp_pkg::ALU_MUL, sh: tmp_pkg::SH_NONE, cap: 1'b0};
                alu_opa = {32'd0, v_eff};
                alu_opb = v_eff;
            end
            ST_FDIV: begin
                alu_req.op = tmp_pkg::ALU_DIV;
                alu_opa    = r_full;
                alu_opb    = a_eff;
            end
            ST_RAMP: begin
                alu_req.op = tmp_pkg::ALU_DIV;
                alu_opa    = {32'd0, v_eff} << FRAC_BITS;
                alu_opb    = a_eff;
            end
            ST_CRU: begin
                alu_req.op = tmp_pkg::ALU_DIV;
                alu_opa    = ({32'd0, r_dist} - r_full) << FRAC_BITS;
                alu_opb    = v_eff;
            end
            ST_QDIV: begin
                alu_req.op = tmp_pkg::ALU_DIV;
                alu_opa    = {32'd0, r_dist} << FRAC_BITS;
                alu_opb    = a_eff;
            end
            ST_SQRT: begin
                alu_req.op = tmp_pkg::ALU_SQRT;
                alu_opa    = r_full << FRAC_BITS;
            end
            ST_PEAK: begin
                alu_opa = {32'd0, r_ramp};
                alu_opb = a_eff;
            end
            ST_TA1: ;
            ST_TA2: begin
                alu_req.sh = tmp_pkg::SH_F1;
                alu_opa    = {23'd0, r_m};
            end
            ST_TPV: begin
                alu_opa = {32'd0, r_peak};
                alu_opb = r_cruise;
            end
            ST_TPD: begin
                alu_opa = {32'd0, r_peak};
                alu_opb = r_y3;
            end
            ST_TB1: alu_opb = r_y3;
            ST_TB2: begin
                alu_req.sh = tmp_pkg::SH_F1;
                alu_opa    = {23'd0, r_m};
                alu_opb    = r_y3;
            end
            default: alu_state = 1'b0;
        endcase
    end

    assign alu_start = alu_state && !r_issued;

    tmp_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (alu_start),
        .i_req   (alu_req),
        .i_opa   (alu_opa),
        .i_opb   (alu_opb),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    always_comb begin
        diff     = 33'(i_cmd.target_position) - 33'(i_cmd.start_position);
        abs_diff = diff[32] ? 32'(-diff) : diff[31:0];
        tick_eff = ({48'd0, r_tick} << SHL) >> SHR;
        el_sum   = {1'b0, r_elapsed} + tick_eff[32:0];
        el_next  = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
        ta_tv    = {1'b0, r_ramp} + {1'b0, r_cruise};
        res_p    = $signed({3'd0, alu_res[40:0]});
        pv       = r_neg ? -r_v : r_v;
        pp       = r_neg ? -r_p : r_p;
        pos_sum  = 46'(r_origin) + 46'(pp);
        acc_flip = (r_phase == PH_DEC) ^ r_neg;
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_mode     = r_mode;
        n_origin   = r_origin;
        n_goal     = r_goal;
        n_neg      = r_neg;
        n_dist     = r_dist;
        n_ramp     = r_ramp;
        n_cruise   = r_cruise;
        n_peak     = r_peak;
        n_elapsed  = r_elapsed;
        n_dur      = r_dur;
        n_hpos     = r_hpos;
        n_hvel     = r_hvel;
        n_hacc     = r_hacc;
        n_accepted = r_accepted;
        n_full     = r_full;
        n_m        = r_m;
        n_p        = r_p;
        n_v        = r_v;
        n_x1       = r_x1;
        n_y3       = r_y3;
        n_issued   = r_issued;
        n_ovalid   = r_ovalid && !o_res.ready;
        if (alu_start) n_issued = 1'b1;
        if (alu_done)  n_issued = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_accepted = 1'b1;
                    n_state    = ST_OUT;
                    case (i_cmd.command)
                        tmp_pkg::CMD_PLAN: begin
                            if (r_mode == tmp_pkg::MODE_MOVING) begin
                                n_accepted = 1'b0;
                            end else begin
                                n_origin  = i_cmd.start_position;
                                n_goal    = i_cmd.target_position;
                                n_neg     = diff[32];
                                n_dist    = abs_diff;
                                n_hpos    = i_cmd.start_position;
                                n_hvel    = '0;
                                n_hacc    = '0;
                                n_elapsed = '0;
                                if (abs_diff == 32'd0) begin
                                    n_ramp   = '0;
                                    n_cruise = '0;
                                    n_peak   = '0;
                                    n_dur    = '0;
                                    n_mode   = tmp_pkg::MODE_DONE;
                                end else begin
                                    n_state = ST_FULL;
                                end
                            end
                        end
                        tmp_pkg::CMD_TICK: begin
                            if (r_mode == tmp_pkg::MODE_MOVING) begin
                                n_elapsed = el_next;
                                if (el_next >= r_dur) begin
                                    n_mode = tmp_pkg::MODE_DONE;
                                    n_hpos = r_goal;
                                    n_hvel = '0;
                                    n_hacc = '0;
                                end else begin
                                    n_state = ST_TA1;
                                    if (el_next < r_ramp) begin
                                        n_phase = PH_ACC;
                                        n_x1    = el_next;
                                    end else if ({1'b0, el_next} < ta_tv) begin
                                        n_phase = PH_CRU;
                                        n_x1    = r_ramp;
                                        n_y3    = el_next - r_ramp;
                                        n_v     = $signed({10'd0, r_peak});
                                    end else begin
                                        n_phase = PH_DEC;
                                        n_x1    = r_ramp;
                                        n_y3    = el_next - r_ramp - r_cruise;
                                    end
                                end
                            end
                        end
                        tmp_pkg::CMD_STOP: begin
                            n_mode    = tmp_pkg::MODE_IDLE;
                            n_elapsed = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FULL: if (alu_done) begin
                n_full  = alu_res;
                n_state = ST_FDIV;
            end
            ST_FDIV: if (alu_done) begin
                n_full  = alu_res;
                n_state = ({32'd0, r_dist} > alu_res) ? ST_RAMP : ST_QDIV;
            end
            ST_RAMP: if (alu_done) begin
                n_ramp  = (alu_res[63:32] != 32'd0) ? 32'hFFFF_FFFF : alu_res[31:0];
                n_state = ST_CRU;
            end
            ST_CRU: if (alu_done) begin
                n_cruise = (alu_res[63:32] != 32'd0) ? 32'hFFFF_FFFF : alu_res[31:0];
                n_peak   = v_eff;
                n_state  = ST_FIN;
            end
            ST_QDIV: if (alu_done) begin
                if ((alu_res >> (64 - FRAC_BITS)) != 64'd0) begin
                    n_ramp  = 32'hFFFF_FFFF;
                    n_state = ST_PEAK;
                end else begin
                    n_full  = alu_res;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: if (alu_done) begin
                n_ramp  = alu_res[31:0];
                n_state = ST_PEAK;
            end
            ST_PEAK: if (alu_done) begin
                n_peak   = (alu_res[63:32] != 32'd0) ? 32'hFFFF_FFFF : alu_res[31:0];
                n_cruise = '0;
                n_state  = ST_FIN;
            end
            ST_FIN: begin
                // 2*ramp + cruise fits 34 bits
                if (({2'b00, r_ramp, 1'b0} + {2'b00, r_cruise}) > 35'h0_FFFF_FFFF)
                    n_dur = 32'hFFFF_FFFF;
                else
                    n_dur = 32'({r_ramp, 1'b0} + {1'b0, r_cruise});
                n_mode  = tmp_pkg::MODE_MOVING;
                n_state = ST_OUT;
            end
            ST_TA1: if (alu_done) begin
                n_m = alu_res[40:0];
                if (r_phase == PH_ACC) n_v = $signed({1'b0, alu_res[40:0]});
                n_state = ST_TA2;
            end
            ST_TA2: if (alu_done) begin
                n_p = res_p;
                case (r_phase)
                    PH_ACC:  n_state = ST_TEND;
                    PH_CRU:  n_state = ST_TPD;
                    default: n_state = ST_TPV;
                endcase
            end
            ST_TPV: if (alu_done) begin
                n_p     = r_p + res_p;
                n_state = ST_TPD;
            end
            ST_TPD: if (alu_done) begin
                n_p     = r_p + res_p;
                n_state = (r_phase == PH_CRU) ? ST_TEND : ST_TB1;
            end
            ST_TB1: if (alu_done) begin
                n_m     = alu_res[40:0];
                n_v     = $signed({10'd0, r_peak}) - $signed({1'b0, alu_res[40:0]});
                n_state = ST_TB2;
            end
            ST_TB2: if (alu_done) begin
                n_p     = r_p - res_p;
                n_state = ST_TEND;
            end
            ST_TEND: begin
                if (pv > VMAX_P)      n_hvel = 33'(VMAX_P);
                else if (pv < VMAX_N) n_hvel = 33'(VMAX_N);
                else                  n_hvel = pv[32:0];
                if (pos_sum > PMAX)      n_hpos = 32'(PMAX);
                else if (pos_sum < PMIN) n_hpos = 32'(PMIN);
                else                     n_hpos = pos_sum[31:0];
                if (r_phase == PH_CRU) n_hacc = '0;
                else if (acc_flip)     n_hacc = -$signed({1'b0, a_eff});
                else                   n_hacc = $signed({1'b0, a_eff});
                n_state = ST_OUT;
            end
            ST_OUT: begin
                n_ovalid = 1'b1;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_mode     <= tmp_pkg::MODE_IDLE;
            r_origin   <= '0;
            r_goal     <= '0;
            r_neg      <= 1'b0;
            r_dist     <= '0;
            r_ramp     <= '0;
            r_cruise   <= '0;
            r_peak     <= '0;
            r_elapsed  <= '0;
            r_dur      <= '0;
            r_hpos     <= '0;
            r_hvel     <= '0;
            r_hacc     <= '0;
            r_issued   <= 1'b0;
            r_ovalid   <= 1'b0;
            r_accepted <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_origin   <= n_origin;
            r_goal     <= n_goal;
            r_neg      <= n_neg;
            r_dist     <= n_dist;
            r_ramp     <= n_ramp;
            r_cruise   <= n_cruise;
            r_peak     <= n_peak;
            r_elapsed  <= n_elapsed;
            r_dur      <= n_dur;
            r_hpos     <= n_hpos;
            r_hvel     <= n_hvel;
            r_hacc     <= n_hacc;
            r_issued   <= n_issued;
            r_ovalid   <= n_ovalid;
            r_accepted <= n_accepted;
        end
        r_phase <= n_phase;
        r_full  <= n_full;
        r_m     <= n_m;
        r_p     <= n_p;
        r_v     <= n_v;
        r_x1    <= n_x1;
        r_y3    <= n_y3;
        if (r_state == ST_OUT) begin
            r_oacc  <= r_accepted;
            r_ostat <= r_mode;
            r_opos  <= r_hpos;
            r_ovel  <= r_hvel;
            r_oacl  <= r_hacc;
        end
    end

    assign o_res.valid        = r_ovalid;
    assign o_res.accepted     = r_oacc;
    assign o_res.status       = r_ostat;
    assign o_res.position     = r_opos;
    assign o_res.velocity     = r_ovel;
    assign o_res.acceleration = r_oacl;

endmodule
`default_nettype wire

>>> design/tmp_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared multicycle unit: shift-add multiply (32 steps), restoring divide
// (64 steps), digit-by-digit square root (32 steps).
module tmp_alu #(
    parameter int FRAC_BITS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  var tmp_pkg::t_alu_req        i_req,
    input  wire  [tmp_pkg::OPA_W-1:0]    i_opa,
    input  wire  [tmp_pkg::OPB_W-1:0]    i_opb,
    output logic                         o_done,
    output logic [tmp_pkg::OPA_W-1:0]    o_res
);
    localparam logic [72:0] TERM_CAP = 73'd1 << 40;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [5:0]        r_cnt, n_cnt;
    tmp_pkg::t_alu_req r_req, n_req;
    logic [72:0]       r_acc, n_acc;
    logic [63:0]       r_sh, n_sh;
    logic [40:0]       r_opd, n_opd;

    logic [32:0] div_t;
    logic        div_ge;
    logic [35:0] sq_r2, sq_trial;
    logic        sq_ge;
    logic [72:0] mul_shifted;

    always_comb begin
        div_t    = {r_acc[31:0], r_sh[63]};
        div_ge   = div_t >= {1'b0, r_opd[31:0]};
        sq_r2    = {r_acc[33:0], r_sh[63:62]};
        sq_trial = {2'b00, r_opd[31:0], 2'b01};
        sq_ge    = sq_r2 >= sq_trial;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_req  = r_req;
        n_acc  = r_acc;
        n_sh   = r_sh;
        n_opd  = r_opd;
        if (i_start) begin
            n_busy = 1'b1;
            n_req  = i_req;
            n_acc  = '0;
            case (i_req.op)
                tmp_pkg::ALU_MUL: begin
                    n_sh  = {i_opb, 32'd0};
                    n_opd = i_opa[40:0];
                    n_cnt = 6'd31;
                end
                tmp_pkg::ALU_DIV: begin
                    n_sh  = i_opa;
                    n_opd = {9'd0, i_opb};
                    n_cnt = 6'd63;
                end
                default: begin
                    n_sh  = i_opa;
                    n_opd = '0;
                    n_cnt = 6'd31;
                end
            endcase
        end else if (r_busy) begin
            case (r_req.op)
                tmp_pkg::ALU_MUL: begin
                    n_acc = {r_acc[71:0], 1'b0} + (r_sh[63] ? {32'd0, r_opd} : 73'd0);
                    n_sh  = {r_sh[62:0], 1'b0};
                end
                tmp_pkg::ALU_DIV: begin
                    n_acc[31:0] = div_ge ? 32'(div_t - {1'b0, r_opd[31:0]}) : div_t[31:0];
                    n_sh        = {r_sh[62:0], div_ge};
                end
                default: begin
                    n_acc[33:0] = sq_ge ? 34'(sq_r2 - sq_trial) : sq_r2[33:0];
                    n_opd[31:0] = {r_opd[30:0], sq_ge};
                    n_sh        = {r_sh[61:0], 2'b00};
                end
            endcase
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_req <= n_req;
        r_acc <= n_acc;
        r_sh  <= n_sh;
        r_opd <= n_opd;
    end

    always_comb begin
        case (r_req.sh)
            tmp_pkg::SH_F:  mul_shifted = r_acc >> FRAC_BITS;
            tmp_pkg::SH_F1: mul_shifted = r_acc >> (FRAC_BITS + 1);
            default:        mul_shifted = r_acc;
        endcase
        if (r_req.cap && (mul_shifted > TERM_CAP))
            mul_shifted = TERM_CAP;
        case (r_req.op)
            tmp_pkg::ALU_MUL: o_res = mul_shifted[63:0];
            tmp_pkg::ALU_DIV: o_res = r_sh;
            default:          o_res = {32'd0, r_opd[31:0]};
        endcase
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

>>> design/tmp_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module tmp_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire        i_accepted,
    input wire [1:0]  i_status,
    input wire [31:0] i_position,
    input wire [32:0] i_velocity,
    input wire [32:0] i_acceleration
);
    // a result waiting on the receiver stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_position)
            && $stable(i_velocity) && $stable(i_status))
        else $error("result dropped or changed while stalled");

    // one command in flight: ready drops right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second command taken while one is in flight");

    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_accepted |-> i_status == tmp_pkg::MODE_MOVING)
        else $error("plan rejected while not moving");

    a_done_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == tmp_pkg::MODE_DONE
            |-> i_velocity == 33'd0 && i_acceleration == 33'd0)
        else $error("finished move reports motion");

endmodule

bind trapezoidal_motion_profile tmp_chk u_tmp_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_cmd.valid),
    .i_in_ready     (i_cmd.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_accepted     (o_res.accepted),
    .i_status       (o_res.status),
    .i_position     (o_res.position),
    .i_velocity     (o_res.velocity),
    .i_acceleration (o_res.acceleration)
);
`default_nettype wire
